FILE: hw/rtl/cvm_pkg.sv
// Shared constants, types and helper functions for the camera view matrix pipeline.
package cvm_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int AXIS_W    = FRAC_BITS + 2;
   localparam int SC_W      = 30;
   localparam int MAG_W     = 2 * SC_W + 1;
   localparam int POS_W     = $clog2(MAG_W);
   localparam int SUM_W     = 2 * SC_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int NUM_W     = SC_W + FRAC_BITS + 1;
   localparam int DIV_STEPS = AXIS_W;
   localparam int PROD_W    = AXIS_W + WORD_BITS;
   localparam int DOT_W     = PROD_W + 2;

   localparam int FRONT_LAT = 4;
   localparam int NORM_LAT  = 4 + ROOT_W + 1 + DIV_STEPS + 1;
   localparam int DOT_LAT   = 3;
   localparam int TOTAL_LAT = FRONT_LAT + NORM_LAT + DOT_LAT;

   typedef logic [MAG_W-1:0]            mag_type;
   typedef logic signed [AXIS_W-1:0]    axis_type;
   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [2:0]           neg;
      logic                 zero;
      logic [2:0][SC_W-1:0] mag;
   } carry_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } sign_type;

   function automatic logic [WORD_BITS-1:0] word_mag(input word_type v);
      return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
   endfunction

   function automatic logic [POS_W-1:0] msb_pos(input mag_type m);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (m[i]) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   // Brings the leading one of the largest magnitude to bit SC_W-1.
   function automatic logic [SC_W-1:0] scale_mag(input mag_type m, input logic [POS_W-1:0] p);
      mag_type s;
      if (p >= POS_W'(SC_W - 1)) begin
         s = m >> (p - POS_W'(SC_W - 1));
      end else begin
         s = m << (POS_W'(SC_W - 1) - p);
      end
      return s[SC_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/cvm_front.sv
// Block scaling of look and up vectors and the pipelined cross product up x look.
module cvm_front import cvm_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type look [3],
   input  word_type up [3],
   output logic [2:0] cross_neg,
   output mag_type  cross_mag [3]
);

   localparam int PW = 2 * SC_W + 2;
   localparam int DW = 2 * SC_W + 3;

   logic [WORD_BITS-1:0]     lk_mag_in [3];
   logic [WORD_BITS-1:0]     up_mag_in [3];
   logic [WORD_BITS-1:0]     lk_or_in;
   logic [WORD_BITS-1:0]     up_or_in;

   logic [2:0]               lk_neg_ff, up_neg_ff;
   logic [WORD_BITS-1:0]     lk_mag_ff [3];
   logic [WORD_BITS-1:0]     up_mag_ff [3];
   logic [POS_W-1:0]         lk_pos_ff, up_pos_ff;
   logic                     lk_zero_ff, up_zero_ff;

   logic signed [SC_W:0]     lk_sc_in [3];
   logic signed [SC_W:0]     up_sc_in [3];
   logic signed [SC_W:0]     lk_sc_ff [3];
   logic signed [SC_W:0]     up_sc_ff [3];
   logic                     zero2_ff;

   logic signed [PW-1:0]     prod_ff [6];
   logic                     zero3_ff;

   logic signed [DW-1:0]     diff_in [3];
   logic [2:0]               cross_neg_ff;
   mag_type                  cross_mag_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lk_mag_in[i] = word_mag(look[i]);
         up_mag_in[i] = word_mag(up[i]);
      end
      lk_or_in = lk_mag_in[0] | lk_mag_in[1] | lk_mag_in[2];
      up_or_in = up_mag_in[0] | up_mag_in[1] | up_mag_in[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            lk_neg_ff[i] <= look[i][WORD_BITS-1];
            up_neg_ff[i] <= up[i][WORD_BITS-1];
            lk_mag_ff[i] <= lk_mag_in[i];
            up_mag_ff[i] <= up_mag_in[i];
         end
         lk_pos_ff  <= msb_pos(MAG_W'(lk_or_in));
         up_pos_ff  <= msb_pos(MAG_W'(up_or_in));
         lk_zero_ff <= (lk_or_in == '0);
         up_zero_ff <= (up_or_in == '0);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lk_sc_in[i] = $signed({1'b0, scale_mag(MAG_W'(lk_mag_ff[i]), lk_pos_ff)});
         up_sc_in[i] = $signed({1'b0, scale_mag(MAG_W'(up_mag_ff[i]), up_pos_ff)});
         if (lk_neg_ff[i]) begin
            lk_sc_in[i] = -lk_sc_in[i];
         end
         if (up_neg_ff[i]) begin
            up_sc_in[i] = -up_sc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lk_sc_ff <= lk_sc_in;
         up_sc_ff <= up_sc_in;
         zero2_ff <= lk_zero_ff | up_zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= up_sc_ff[1] * lk_sc_ff[2];
         prod_ff[1] <= up_sc_ff[2] * lk_sc_ff[1];
         prod_ff[2] <= up_sc_ff[2] * lk_sc_ff[0];
         prod_ff[3] <= up_sc_ff[0] * lk_sc_ff[2];
         prod_ff[4] <= up_sc_ff[0] * lk_sc_ff[1];
         prod_ff[5] <= up_sc_ff[1] * lk_sc_ff[0];
         zero3_ff   <= zero2_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = DW'(prod_ff[2*i]) - DW'(prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cross_neg_ff[i] <= diff_in[i][DW-1] & ~zero3_ff;
            if (zero3_ff) begin
               cross_mag_ff[i] <= '0;
            end else if (diff_in[i][DW-1]) begin
               cross_mag_ff[i] <= MAG_W'(-diff_in[i]);
            end else begin
               cross_mag_ff[i] <= MAG_W'(diff_in[i]);
            end
         end
      end
   end

   assign cross_neg = cross_neg_ff;
   assign cross_mag = cross_mag_ff;

endmodule

FILE: hw/rtl/cvm_norm.sv
// Vector normalization pipeline: block scale, sum of squares, square root and division.
module cvm_norm import cvm_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  logic [2:0] neg_in,
   input  mag_type  mag_in [3],
   output axis_type axis_out [3]
);

   localparam logic [AXIS_W-1:0] ONE = AXIS_W'(1) << FRAC_BITS;

   mag_type             or_in;
   logic [2:0]          n1_neg_ff;
   mag_type             n1_mag_ff [3];
   logic [POS_W-1:0]    n1_pos_ff;
   logic                n1_zero_ff;

   carry_type           n2_car_ff;
   logic [2*SC_W-1:0]   n3_sq_ff [3];
   carry_type           n3_car_ff;

   logic [SUM_W-1:0]    rt_s_ff    [ROOT_W+1];
   logic [REM_W-1:0]    rt_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]   rt_root_ff [ROOT_W+1];
   carry_type           rt_car_ff  [ROOT_W+1];

   logic [NUM_W-1:0]    dv_rem_ff [DIV_STEPS+1][3];
   logic [DIV_STEPS-1:0] dv_quo_ff [DIV_STEPS+1][3];
   logic [ROOT_W-1:0]   dv_r_ff   [DIV_STEPS+1];
   sign_type            dv_sgn_ff [DIV_STEPS+1];

   axis_type            axis_in [3];
   axis_type            axis_ff [3];

   assign or_in = mag_in[0] | mag_in[1] | mag_in[2];

   always_ff @(posedge clock) begin
      if (en) begin
         n1_neg_ff  <= neg_in;
         n1_mag_ff  <= mag_in;
         n1_pos_ff  <= msb_pos(or_in);
         n1_zero_ff <= (or_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n2_car_ff.neg  <= n1_neg_ff;
         n2_car_ff.zero <= n1_zero_ff;
         for (int i = 0; i < 3; i++) begin
            n2_car_ff.mag[i] <= scale_mag(n1_mag_ff[i], n1_pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n3_sq_ff[i] <= n2_car_ff.mag[i] * n2_car_ff.mag[i];
         end
         n3_car_ff <= n2_car_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_s_ff[0]    <= SUM_W'(n3_sq_ff[0]) + SUM_W'(n3_sq_ff[1]) + SUM_W'(n3_sq_ff[2]);
         rt_rem_ff[0]  <= '0;
         rt_root_ff[0] <= '0;
         rt_car_ff[0]  <= n3_car_ff;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W+1:0] rem_sh_in;
      logic [REM_W+1:0] trial_in;
      logic             ge_in;

      always_comb begin
         rem_sh_in = {rt_rem_ff[k], rt_s_ff[k][SUM_W-1-2*k -: 2]};
         trial_in  = (REM_W+2)'({rt_root_ff[k], 2'b01});
         ge_in     = (rem_sh_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_s_ff[k+1]    <= rt_s_ff[k];
            rt_rem_ff[k+1]  <= ge_in ? REM_W'(rem_sh_in - trial_in) : REM_W'(rem_sh_in);
            rt_root_ff[k+1] <= {rt_root_ff[k][ROOT_W-2:0], ge_in};
            rt_car_ff[k+1]  <= rt_car_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= NUM_W'({rt_car_ff[ROOT_W].mag[i], {FRAC_BITS{1'b0}}})
                               + NUM_W'(rt_root_ff[ROOT_W] >> 1);
            dv_quo_ff[0][i] <= '0;
         end
         dv_r_ff[0]        <= rt_root_ff[ROOT_W];
         dv_sgn_ff[0].neg  <= rt_car_ff[ROOT_W].neg;
         dv_sgn_ff[0].zero <= rt_car_ff[ROOT_W].zero;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int B = DIV_STEPS - 1 - k;
      logic [NUM_W+1:0]     cmp_in;
      logic [2:0]           ge_in;
      logic [DIV_STEPS-1:0] quo_in [3];

      always_comb begin
         cmp_in = (NUM_W+2)'(dv_r_ff[k]) << B;
         for (int i = 0; i < 3; i++) begin
            ge_in[i]     = ((NUM_W+2)'(dv_rem_ff[k][i]) >= cmp_in);
            quo_in[i]    = dv_quo_ff[k][i];
            quo_in[i][B] = ge_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[k+1][i] <= ge_in[i] ? NUM_W'((NUM_W+2)'(dv_rem_ff[k][i]) - cmp_in)
                                             : dv_rem_ff[k][i];
               dv_quo_ff[k+1][i] <= quo_in[i];
            end
            dv_r_ff[k+1]   <= dv_r_ff[k];
            dv_sgn_ff[k+1] <= dv_sgn_ff[k];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [AXIS_W-1:0] q;
         q = AXIS_W'(dv_quo_ff[DIV_STEPS][i]);
         if (q > ONE) begin
            q = ONE;
         end
         if (dv_sgn_ff[DIV_STEPS].zero) begin
            axis_in[i] = '0;
         end else if (dv_sgn_ff[DIV_STEPS].neg[i]) begin
            axis_in[i] = -$signed(q);
         end else begin
            axis_in[i] = $signed(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axis_ff <= axis_in;
      end
   end

   assign axis_out = axis_ff;

endmodule

FILE: hw/rtl/cvm_dot.sv
// Translation terms: rounded, negated and saturated dot products of the axes with the position.
module cvm_dot import cvm_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  axis_type axis_in [3][3],
   input  word_type pos_in [3],
   output axis_type row_out [3][3],
   output word_type trans_out [3]
);

   localparam int SW = DOT_W - FRAC_BITS;
   localparam logic signed [SW:0] SAT_HI = {{(SW - WORD_BITS + 2){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [SW:0] SAT_LO = ~SAT_HI;
   localparam logic signed [DOT_W-1:0] HALF = DOT_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff [3][3];
   axis_type                 row1_ff [3][3];
   logic signed [DOT_W-1:0]  sum_in [3];
   logic signed [SW-1:0]     dot_ff [3];
   axis_type                 row2_ff [3][3];
   logic signed [SW:0]       neg_in [3];
   word_type                 sat_in [3];
   word_type                 trans_ff [3];
   axis_type                 row3_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[r][i] <= axis_in[r][i] * pos_in[i];
            end
         end
         row1_ff <= axis_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = DOT_W'(prod_ff[r][0]) + DOT_W'(prod_ff[r][1]) + DOT_W'(prod_ff[r][2])
                     + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            dot_ff[r] <= SW'(sum_in[r] >>> FRAC_BITS);
         end
         row2_ff <= row1_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         neg_in[r] = -((SW+1)'(dot_ff[r]));
         if (neg_in[r] > SAT_HI) begin
            sat_in[r] = WORD_BITS'(SAT_HI);
         end else if (neg_in[r] < SAT_LO) begin
            sat_in[r] = WORD_BITS'(SAT_LO);
         end else begin
            sat_in[r] = WORD_BITS'(neg_in[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trans_ff <= sat_in;
         row3_ff  <= row2_ff;
      end
   end

   assign row_out   = row3_ff;
   assign trans_out = trans_ff;

endmodule

FILE: hw/rtl/camera_view_matrix.sv
// Top level of the camera view matrix pipeline with handshake control and checks.
//
// One camera (look direction, up vector, position, signed Q15.16) enters on the
// req_ channel with each transfer; one 3x4 view matrix leaves on the rsp_ channel.
// The x, y and z axes are the normalized cross product up x look, the normalized up
// vector and the normalized look vector, in Q1.16 within [-1, 1]; the translation
// terms are the negated dot products of each axis with the position, saturated.
// The path holds 62 register stages, the first of which captures the req_ transfer
// and the last of which drives rsp_valid: 4 stages of block scaling and cross
// product, 55 of normalization (a 31-stage square root and an 18-stage divider,
// one result bit per stage) and 3 of dot product.
// Throughput is one camera per cycle while the output is not stalled; every stage is a register with a valid bit.
// When the receiver holds rsp_ready low with a result waiting, the whole pipeline
// holds and req_ready falls; nothing is lost or repeated, and it resumes in the
// cycle rsp_ready returns. Reset clears all valid bits.
module camera_view_matrix import cvm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_BITS-1:0] req_look_x,
   input  logic signed [WORD_BITS-1:0] req_look_y,
   input  logic signed [WORD_BITS-1:0] req_look_z,
   input  logic signed [WORD_BITS-1:0] req_up_x,
   input  logic signed [WORD_BITS-1:0] req_up_y,
   input  logic signed [WORD_BITS-1:0] req_up_z,
   input  logic signed [WORD_BITS-1:0] req_pos_x,
   input  logic signed [WORD_BITS-1:0] req_pos_y,
   input  logic signed [WORD_BITS-1:0] req_pos_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [AXIS_W-1:0] rsp_row0_x,
   output logic signed [AXIS_W-1:0] rsp_row0_y,
   output logic signed [AXIS_W-1:0] rsp_row0_z,
   output logic signed [AXIS_W-1:0] rsp_row1_x,
   output logic signed [AXIS_W-1:0] rsp_row1_y,
   output logic signed [AXIS_W-1:0] rsp_row1_z,
   output logic signed [AXIS_W-1:0] rsp_row2_x,
   output logic signed [AXIS_W-1:0] rsp_row2_y,
   output logic signed [AXIS_W-1:0] rsp_row2_z,
   output logic signed [WORD_BITS-1:0] rsp_trans_x,
   output logic signed [WORD_BITS-1:0] rsp_trans_y,
   output logic signed [WORD_BITS-1:0] rsp_trans_z
);

   localparam int POS_DLY = FRONT_LAT + NORM_LAT;

   logic                 en;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic [TOTAL_LAT-1:0] vld_in;

   word_type   look [3];
   word_type   up [3];
   word_type   pos [3];
   logic [2:0] up_neg, lk_neg, cross_neg;
   mag_type    up_mag [3];
   mag_type    lk_mag [3];
   mag_type    cross_mag [3];

   axis_type   ax_x [3];
   axis_type   ax_y [3];
   axis_type   ax_z [3];
   axis_type   ay_dly_ff [FRONT_LAT][3];
   axis_type   az_dly_ff [FRONT_LAT][3];
   word_type   pos_dly_ff [POS_DLY][3];

   axis_type   dot_axis [3][3];
   axis_type   row [3][3];
   word_type   trans [3];

   assign en        = !vld_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL_LAT-1];

   assign vld_in = {vld_ff[TOTAL_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign look = '{req_look_x, req_look_y, req_look_z};
   assign up   = '{req_up_x, req_up_y, req_up_z};
   assign pos  = '{req_pos_x, req_pos_y, req_pos_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up_neg[i] = up[i][WORD_BITS-1];
         lk_neg[i] = look[i][WORD_BITS-1];
         up_mag[i] = MAG_W'(word_mag(up[i]));
         lk_mag[i] = MAG_W'(word_mag(look[i]));
      end
   end

   cvm_front u_front (
      .clock     (clock),
      .en        (en),
      .look      (look),
      .up        (up),
      .cross_neg (cross_neg),
      .cross_mag (cross_mag)
   );

   cvm_norm u_norm_x (
      .clock    (clock),
      .en       (en),
      .neg_in   (cross_neg),
      .mag_in   (cross_mag),
      .axis_out (ax_x)
   );

   cvm_norm u_norm_y (
      .clock    (clock),
      .en       (en),
      .neg_in   (up_neg),
      .mag_in   (up_mag),
      .axis_out (ax_y)
   );

   cvm_norm u_norm_z (
      .clock    (clock),
      .en       (en),
      .neg_in   (lk_neg),
      .mag_in   (lk_mag),
      .axis_out (ax_z)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ay_dly_ff[0]  <= ax_y;
         az_dly_ff[0]  <= ax_z;
         pos_dly_ff[0] <= pos;
         for (int k = 1; k < FRONT_LAT; k++) begin
            ay_dly_ff[k] <= ay_dly_ff[k-1];
            az_dly_ff[k] <= az_dly_ff[k-1];
         end
         for (int k = 1; k < POS_DLY; k++) begin
            pos_dly_ff[k] <= pos_dly_ff[k-1];
         end
      end
   end

   assign dot_axis[0] = ax_x;
   assign dot_axis[1] = ay_dly_ff[FRONT_LAT-1];
   assign dot_axis[2] = az_dly_ff[FRONT_LAT-1];

   cvm_dot u_dot (
      .clock     (clock),
      .en        (en),
      .axis_in   (dot_axis),
      .pos_in    (pos_dly_ff[POS_DLY-1]),
      .row_out   (row),
      .trans_out (trans)
   );

   assign rsp_row0_x  = row[0][0];
   assign rsp_row0_y  = row[0][1];
   assign rsp_row0_z  = row[0][2];
   assign rsp_row1_x  = row[1][0];
   assign rsp_row1_y  = row[1][1];
   assign rsp_row1_z  = row[1][2];
   assign rsp_row2_x  = row[2][0];
   assign rsp_row2_y  = row[2][1];
   assign rsp_row2_z  = row[2][2];
   assign rsp_trans_x = trans[0];
   assign rsp_trans_y = trans[1];
   assign rsp_trans_z = trans[2];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
      else $error("pipeline moved while the result was stalled");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transfer did not enter the pipeline");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row0_x <= 18'sd65536 && rsp_row0_x >= -18'sd65536 &&
                     rsp_row1_y <= 18'sd65536 && rsp_row1_y >= -18'sd65536 &&
                     rsp_row2_z <= 18'sd65536 && rsp_row2_z >= -18'sd65536))
      else $error("axis component outside unit range");

endmodule
